/* hw/rtl/pga_pkg.sv */
package pga_pkg;

    // Number of axes held in the state memory
    localparam int NUM_AXES = 3;
    localparam int ADDR_W   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // Tuning constants
    localparam int        STICK_HOLD    = 50;
    localparam int        GATE_RELOAD   = 10;
    localparam logic [7:0] P_MAX         = 8'd200;
    localparam logic [7:0] I_MAX         = 8'd100;
    localparam logic [7:0] I_WOBBLE_STEP = 8'd10;

    // Configuration register indexes
    localparam logic [2:0] REG_STICK_DEADBAND   = 3'd0;
    localparam logic [2:0] REG_RISE_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_FALL_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_WOBBLE_HOLD      = 3'd3;
    localparam logic [2:0] REG_AVG_ERROR_BAND   = 3'd4;
    localparam logic [2:0] REG_I_WINDOW         = 3'd5;
    localparam logic [2:0] REG_WOBBLE_AMPLITUDE = 3'd6;
    localparam logic [2:0] REG_WOBBLE_PERIOD    = 3'd7;

    // Sample kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_PRESET = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         axis;
        logic signed [11:0] stick;
        logic signed [15:0] error;
        logic               airborne;
        logic [7:0]         preset_p;
        logic [6:0]         preset_i;
    } sample_t;

    typedef struct packed {
        logic [7:0] p_gain;
        logic [7:0] i_gain;
        logic [7:0] saved_p;
        logic [7:0] saved_i;
        logic       led_on;
    } result_t;

    typedef struct packed {
        logic [7:0] stick_deadband;
        logic [7:0] rise_threshold;
        logic [7:0] fall_threshold;
        logic [7:0] wobble_hold;
        logic [7:0] avg_error_band;
        logic [7:0] i_window;
        logic [7:0] wobble_amplitude;
        logic [7:0] wobble_period;
    } cfg_t;

    typedef struct packed {
        logic [5:0]         gate_countdown;
        logic [7:0]         window_count;
        logic signed [15:0] average_error;
        logic signed [15:0] previous_error;
        sign_t              last_sign;
        logic signed [13:0] peak_high;
        logic signed [13:0] peak_low;
        logic [15:0]        wave_counter;
        logic [15:0]        wave_length;
        logic [7:0]         wobble_countdown;
        logic [7:0]         p_store;
        logic [7:0]         i_store;
        logic [7:0]         saved_p_store;
        logic [7:0]         saved_i_store;
    } axis_state_t;

    function automatic logic axis_in_range(input logic [1:0] axis);
        return int'(axis) < NUM_AXES;
    endfunction

endpackage

/* hw/rtl/pga_state_ram.sv */
module pga_state_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  pga_pkg::addr_t      rd_addr,
    output pga_pkg::axis_state_t rd_data,
    input  logic                wr_en,
    input  pga_pkg::addr_t      wr_addr,
    input  pga_pkg::axis_state_t wr_data
);
    import pga_pkg::*;

    axis_state_t           mem [NUM_AXES];
    axis_state_t           rd_data_reg;
    logic                  rd_valid_reg;
    logic [NUM_AXES-1:0]   valid_reg;

    // Write port and registered read; a same-cycle write to the read entry is forwarded
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    // Track written entries so unwritten ones read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= (wr_en && (wr_addr == rd_addr)) || valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/pga_update.sv */
module pga_update (
    input  pga_pkg::sample_t     item,
    input  pga_pkg::axis_state_t cur,
    input  pga_pkg::cfg_t        cfg,
    input  logic                 indicator,
    output pga_pkg::axis_state_t nxt,
    output logic                 indicator_next,
    output pga_pkg::result_t     result
);
    import pga_pkg::*;

    logic               in_range;
    logic               stick_out;
    logic [11:0]        stick_mag;
    logic signed [16:0] err_x;
    logic signed [16:0] err_round;
    logic signed [13:0] e4;
    logic               e4_pos;
    logic               e4_neg;
    logic signed [15:0] peak_span;
    logic               wobble_hit;
    logic [15:0]        wc_base;
    logic signed [13:0] ph_base;
    logic signed [13:0] pl_base;
    logic [7:0]         p_work;
    logic [7:0]         i_work;
    logic signed [16:0] avg_sum;
    logic [16:0]        avg_mag;
    logic [16:0]        err_mag;
    logic [16:0]        prev_mag;
    logic signed [17:0] delta;
    logic signed [17:0] rise_lim;
    logic signed [17:0] fall_lim;
    logic               same_sign;

    // Operand preparation
    always_comb
    begin
        in_range  = axis_in_range(item.axis);
        stick_mag = item.stick[11] ? (~item.stick + 12'd1) : item.stick;
        stick_out = stick_mag > {4'd0, cfg.stick_deadband};
        err_x     = 17'(item.error);
        err_round = item.error[15] ? (err_x + 17'sd3) : err_x;
        e4        = 14'(err_round >>> 2);
        e4_neg    = e4[13];
        e4_pos    = !e4[13] && (e4 != '0);
        peak_span = 16'(cur.peak_high) - 16'(cur.peak_low);
        wobble_hit = (peak_span > $signed({8'd0, cfg.wobble_amplitude}))
                  && (cur.wave_counter > {8'd0, cfg.wobble_period})
                  && (cfg.wobble_amplitude != '0) && (cfg.wobble_period != '0);
        avg_sum   = 17'(cur.average_error) + err_x;
        avg_mag   = cur.average_error[15] ? 17'(-17'(cur.average_error))
                                          : 17'(cur.average_error);
        err_mag   = item.error[15] ? 17'(-err_x) : 17'(err_x);
        prev_mag  = cur.previous_error[15] ? 17'(-17'(cur.previous_error))
                                           : 17'(cur.previous_error);
        delta     = $signed({1'b0, err_mag}) - $signed({1'b0, prev_mag});
        rise_lim  = $signed({10'd0, cfg.rise_threshold});
        fall_lim  = 18'sd0 - $signed({10'd0, cfg.fall_threshold});
        same_sign = (!item.error[15] && !cur.previous_error[15])
                 || ((item.error[15] || (item.error == '0))
                     && (cur.previous_error[15] || (cur.previous_error == '0)));
    end

    // State update for one transaction
    always_comb
    begin
        nxt            = cur;
        indicator_next = indicator;
        wc_base        = cur.wave_counter;
        ph_base        = cur.peak_high;
        pl_base        = cur.peak_low;
        p_work         = cur.p_store;
        i_work         = cur.i_store;

        if (in_range)
        begin
            if (item.kind == KIND_PRESET)
            begin
                nxt.p_store = item.preset_p;
                nxt.i_store = {1'b0, item.preset_i};
            end
            else if (stick_out)
            begin
                nxt.gate_countdown   = 6'(STICK_HOLD);
                nxt.wobble_countdown = 8'(STICK_HOLD);
            end
            else
            begin
                // Wobble tracking on error/4
                if (e4_pos)
                begin
                    if (cur.last_sign != SIGN_POS)
                    begin
                        nxt.wave_length = cur.wave_counter;
                        if (cur.wobble_countdown != '0)
                        begin
                            nxt.wobble_countdown = cur.wobble_countdown - 8'd1;
                        end
                        else
                        begin
                            nxt.wobble_countdown = cfg.wobble_hold;
                            if (wobble_hit)
                            begin
                                if (item.axis == '0)
                                begin
                                    indicator_next = 1'b0;
                                end
                                if (p_work != '0)
                                begin
                                    p_work = p_work - 8'd1;
                                end
                                i_work = (i_work >= I_WOBBLE_STEP) ? (i_work - I_WOBBLE_STEP)
                                                                   : 8'd0;
                            end
                            else if (item.axis == '0)
                            begin
                                indicator_next = 1'b1;
                            end
                        end
                        wc_base = '0;
                        ph_base = '0;
                        pl_base = '0;
                    end
                    nxt.wave_counter = wc_base + 16'd1;
                    nxt.peak_high    = (ph_base < e4) ? e4 : ph_base;
                    nxt.peak_low     = pl_base;
                    nxt.last_sign    = SIGN_POS;
                end
                else if (e4_neg)
                begin
                    nxt.wave_counter = cur.wave_counter + 16'd1;
                    nxt.peak_low     = (cur.peak_low > e4) ? e4 : cur.peak_low;
                    nxt.last_sign    = SIGN_NEG;
                end

                // Gate countdown, then the gated I and P decisions
                if (cur.gate_countdown != '0)
                begin
                    nxt.gate_countdown = cur.gate_countdown - 6'd1;
                end
                else
                begin
                    nxt.gate_countdown = 6'(GATE_RELOAD);
                    if (cur.window_count != '0)
                    begin
                        nxt.average_error = 16'(avg_sum >>> 1);
                        nxt.window_count  = cur.window_count - 8'd1;
                    end
                    else
                    begin
                        if (cfg.avg_error_band != '0)
                        begin
                            if (avg_mag > {9'd0, cfg.avg_error_band})
                            begin
                                if (i_work < I_MAX)
                                begin
                                    i_work = i_work + 8'd1;
                                end
                            end
                            else if (i_work != '0)
                            begin
                                i_work = i_work - 8'd1;
                            end
                        end
                        nxt.average_error = '0;
                        nxt.window_count  = cfg.i_window;
                    end

                    if (same_sign)
                    begin
                        if ((delta > rise_lim) && (cfg.rise_threshold != '0))
                        begin
                            if (p_work < P_MAX)
                            begin
                                p_work = p_work + 8'd1;
                            end
                        end
                        else if ((delta < fall_lim) && (cfg.fall_threshold != '0))
                        begin
                            if (p_work != '0)
                            begin
                                p_work = p_work - 8'd1;
                            end
                        end
                    end

                    if (item.airborne)
                    begin
                        nxt.saved_p_store = p_work;
                        nxt.saved_i_store = i_work;
                    end
                    nxt.previous_error = item.error;
                end
                nxt.p_store = p_work;
                nxt.i_store = i_work;
            end
        end
    end

    // Result of the addressed axis after the update
    always_comb
    begin
        if (in_range)
        begin
            result.p_gain  = nxt.p_store;
            result.i_gain  = nxt.i_store;
            result.saved_p = nxt.saved_p_store;
            result.saved_i = nxt.saved_i_store;
        end
        else
        begin
            result.p_gain  = '0;
            result.i_gain  = '0;
            result.saved_p = '0;
            result.saved_i = '0;
        end
        result.led_on = indicator_next;
    end

endmodule

/* hw/rtl/pid_gain_autotuner_core.sv */
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   pga_pkg::sample_t
// result    out        result_valid / result_ready   pga_pkg::result_t
// config    in         wr_en (no wait)               wr_index, wr_data
//
// One sample per cycle unless results stall; result_valid rises after update.
// Per-axis state sits in a registered-read memory; the state of a sample that
// follows one on the same axis is forwarded from the write port.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// A stalled result register holds the sample in the update stage and drops ready.
module pid_gain_autotuner_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  pga_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_ready,
    output pga_pkg::result_t result,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [7:0]       wr_data
);
    import pga_pkg::*;

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    sample_t     s1_item_reg;
    logic        indicator_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    logic        accept;
    logic        s1_adv;
    addr_t       rd_addr;
    axis_state_t cur_state;
    axis_state_t nxt_state;
    logic        indicator_next;
    result_t     result_next;
    logic        wr_state;

    // Handshake and stage advance
    assign s1_adv       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_adv;
    assign accept       = sample_valid && sample_ready;
    assign rd_addr      = axis_in_range(sample.axis) ? ADDR_W'(sample.axis) : '0;
    assign wr_state     = s1_adv && axis_in_range(s1_item_reg.axis);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_deadband   <= 8'd12;
            cfg_reg.rise_threshold   <= 8'd10;
            cfg_reg.fall_threshold   <= 8'd15;
            cfg_reg.wobble_hold      <= 8'd10;
            cfg_reg.avg_error_band   <= 8'd15;
            cfg_reg.i_window         <= 8'd100;
            cfg_reg.wobble_amplitude <= 8'd0;
            cfg_reg.wobble_period    <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_STICK_DEADBAND:   cfg_reg.stick_deadband   <= wr_data;
                REG_RISE_THRESHOLD:   cfg_reg.rise_threshold   <= wr_data;
                REG_FALL_THRESHOLD:   cfg_reg.fall_threshold   <= wr_data;
                REG_WOBBLE_HOLD:      cfg_reg.wobble_hold      <= wr_data;
                REG_AVG_ERROR_BAND:   cfg_reg.avg_error_band   <= wr_data;
                REG_I_WINDOW:         cfg_reg.i_window         <= wr_data;
                REG_WOBBLE_AMPLITUDE: cfg_reg.wobble_amplitude <= wr_data;
                REG_WOBBLE_PERIOD:    cfg_reg.wobble_period    <= wr_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Per-axis state memory
    pga_state_ram u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (cur_state),
        .wr_en   (wr_state),
        .wr_addr (ADDR_W'(s1_item_reg.axis)),
        .wr_data (nxt_state)
    );

    // Read-modify-write of the addressed axis
    pga_update u_update (
        .item           (s1_item_reg),
        .cur            (cur_state),
        .cfg            (cfg_reg),
        .indicator      (indicator_reg),
        .nxt            (nxt_state),
        .indicator_next (indicator_next),
        .result         (result_next)
    );

    // Update stage control and shared indicator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            indicator_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                indicator_reg    <= indicator_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payloads of the update stage and the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= sample;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import pga_pkg::*;

    localparam int CLK_PERIOD = 10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       sample_valid;
    logic       sample_ready;
    sample_t    sample_in;
    logic       result_valid;
    logic       result_ready;
    result_t    result_out;
    logic       wr_en;
    logic [2:0] wr_index;
    logic [7:0] wr_data;

    // Predictor copy of the tuner: configuration, per-axis state, shared indicator
    cfg_t        tune_cfg;
    axis_state_t axis_q [NUM_AXES];
    logic        led_q;

    // Gains expected back, oldest first
    result_t gains_expected [$];

    int mismatch_count = 0;
    int burst_left     = 0;
    logic steady_sender = 1'b0;
    int hold_off_req   = 0;

    // Per-axis wave generator for well-formed traffic
    int wave_amp  [4];
    int wave_half [4];
    int wave_ph   [4];

    pid_gain_autotuner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the tuner state by one sample and return the gains it reports
    function automatic result_t predict_gains(input sample_t s);
        result_t     r;
        axis_state_t st;
        int          ax;
        int          stick_v;
        int          err_v;
        int          e4;
        int          prev_v;
        int          sum;
        int          delta;
        r = '0;
        ax = int'(s.axis);
        stick_v = $signed(s.stick);
        err_v = $signed(s.error);
        if (ax >= NUM_AXES)
        begin
            r.led_on = led_q;
            return r;
        end
        st = axis_q[ax];
        if (s.kind == KIND_PRESET)
        begin
            st.p_store = s.preset_p;
            st.i_store = {1'b0, s.preset_i};
        end
        else if (magnitude(stick_v) > int'(tune_cfg.stick_deadband))
        begin
            // Pilot input: rearm the hold counters only
            st.gate_countdown = 6'(STICK_HOLD);
            st.wobble_countdown = 8'(STICK_HOLD);
        end
        else
        begin
            // Track wobble on error/4
            e4 = err_v / 4;
            if (e4 > 0)
            begin
                if (st.last_sign != SIGN_POS)
                begin
                    st.wave_length = st.wave_counter;
                    if (st.wobble_countdown != 0)
                        st.wobble_countdown = st.wobble_countdown - 8'd1;
                    else
                    begin
                        st.wobble_countdown = tune_cfg.wobble_hold;
                        if (($signed(st.peak_high) - $signed(st.peak_low))
                                > int'(tune_cfg.wobble_amplitude) &&
                            st.wave_length > 16'(tune_cfg.wobble_period) &&
                            tune_cfg.wobble_amplitude != 0 && tune_cfg.wobble_period != 0)
                        begin
                            if (ax == 0)
                                led_q = 1'b0;
                            if (st.p_store != 0)
                                st.p_store = st.p_store - 8'd1;
                            st.i_store = (st.i_store >= I_WOBBLE_STEP) ?
                                         st.i_store - I_WOBBLE_STEP : 8'd0;
                        end
                        else if (ax == 0)
                            led_q = 1'b1;
                    end
                    st.peak_high = '0;
                    st.peak_low = '0;
                    st.wave_counter = '0;
                end
                st.wave_counter = st.wave_counter + 16'd1;
                if ($signed(st.peak_high) < e4)
                    st.peak_high = 14'(e4);
                st.last_sign = SIGN_POS;
            end
            else if (e4 < 0)
            begin
                st.wave_counter = st.wave_counter + 16'd1;
                if ($signed(st.peak_low) > e4)
                    st.peak_low = 14'(e4);
                st.last_sign = SIGN_NEG;
            end

            // Gate: one sample in every eleven updates the gains
            if (st.gate_countdown != 0)
                st.gate_countdown = st.gate_countdown - 6'd1;
            else
            begin
                st.gate_countdown = 6'(GATE_RELOAD);
                prev_v = $signed(st.previous_error);

                // Windowed average drives I
                if (st.window_count != 0)
                begin
                    sum = $signed(st.average_error) + err_v;
                    st.average_error = 16'(sum >>> 1);
                    st.window_count = st.window_count - 8'd1;
                end
                else
                begin
                    if (tune_cfg.avg_error_band != 0)
                    begin
                        if (magnitude($signed(st.average_error))
                                > int'(tune_cfg.avg_error_band))
                        begin
                            if (st.i_store < I_MAX)
                                st.i_store = st.i_store + 8'd1;
                        end
                        else if (st.i_store != 0)
                            st.i_store = st.i_store - 8'd1;
                    end
                    st.average_error = '0;
                    st.window_count = tune_cfg.i_window;
                end

                // Same-sign growth or shrink drives P
                if ((err_v >= 0 && prev_v >= 0) || (err_v <= 0 && prev_v <= 0))
                begin
                    delta = magnitude(err_v) - magnitude(prev_v);
                    if (delta > int'(tune_cfg.rise_threshold) && tune_cfg.rise_threshold != 0)
                    begin
                        if (st.p_store < P_MAX)
                            st.p_store = st.p_store + 8'd1;
                    end
                    else if (delta < -int'(tune_cfg.fall_threshold) &&
                             tune_cfg.fall_threshold != 0)
                    begin
                        if (st.p_store != 0)
                            st.p_store = st.p_store - 8'd1;
                    end
                end

                if (s.airborne)
                begin
                    st.saved_p_store = st.p_store;
                    st.saved_i_store = st.i_store;
                end
                st.previous_error = s.error;
            end
        end
        axis_q[ax] = st;
        r.p_gain = st.p_store;
        r.i_gain = st.i_store;
        r.saved_p = st.saved_p_store;
        r.saved_i = st.saved_i_store;
        r.led_on = led_q;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // Check each result transaction, then record accepted samples and writes
    always @(posedge clk)
    begin
        result_t want;
        if (result_valid && result_ready)
        begin
            if (gains_expected.size() == 0)
                flag_mismatch("result with nothing pending, p_gain", 8'd0, result_out.p_gain);
            else
            begin
                want = gains_expected.pop_front();
                if (result_out.p_gain !== want.p_gain)
                    flag_mismatch("p_gain", want.p_gain, result_out.p_gain);
                if (result_out.i_gain !== want.i_gain)
                    flag_mismatch("i_gain", want.i_gain, result_out.i_gain);
                if (result_out.saved_p !== want.saved_p)
                    flag_mismatch("saved_p", want.saved_p, result_out.saved_p);
                if (result_out.saved_i !== want.saved_i)
                    flag_mismatch("saved_i", want.saved_i, result_out.saved_i);
                if (result_out.led_on !== want.led_on)
                    flag_mismatch("led_on", 8'(want.led_on), 8'(result_out.led_on));
            end
        end
        if (sample_valid && sample_ready)
            gains_expected.push_back(predict_gains(sample_in));
        if (wr_en)
        begin
            case (wr_index)
                REG_STICK_DEADBAND:   tune_cfg.stick_deadband = wr_data;
                REG_RISE_THRESHOLD:   tune_cfg.rise_threshold = wr_data;
                REG_FALL_THRESHOLD:   tune_cfg.fall_threshold = wr_data;
                REG_WOBBLE_HOLD:      tune_cfg.wobble_hold = wr_data;
                REG_AVG_ERROR_BAND:   tune_cfg.avg_error_band = wr_data;
                REG_I_WINDOW:         tune_cfg.i_window = wr_data;
                REG_WOBBLE_AMPLITUDE: tune_cfg.wobble_amplitude = wr_data;
                REG_WOBBLE_PERIOD:    tune_cfg.wobble_period = wr_data;
                default: ;
            endcase
        end
    end

    // Receiver: stall in phases of random density, or hold off on request
    initial
    begin
        int stall_pct  = 0;
        int phase_left = 0;
        int hold_left  = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req != 0)
            begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left != 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                    phase_left = $urandom_range(10, 80);
                end
                phase_left--;
                result_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one sample transaction; gaps fall between bursts of random length
    task automatic offer_sample(input sample_t item);
        int gap;
        if (!steady_sender && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        sample_in <= item;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic wait_idle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (gains_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        logic [7:0] reg_val [8];
        wait_idle();
        reg_val[REG_STICK_DEADBAND]   = c.stick_deadband;
        reg_val[REG_RISE_THRESHOLD]   = c.rise_threshold;
        reg_val[REG_FALL_THRESHOLD]   = c.fall_threshold;
        reg_val[REG_WOBBLE_HOLD]      = c.wobble_hold;
        reg_val[REG_AVG_ERROR_BAND]   = c.avg_error_band;
        reg_val[REG_I_WINDOW]         = c.i_window;
        reg_val[REG_WOBBLE_AMPLITUDE] = c.wobble_amplitude;
        reg_val[REG_WOBBLE_PERIOD]    = c.wobble_period;
        for (int i = 0; i < 8; i++)
        begin
            wr_en <= 1'b1;
            wr_index <= 3'(i);
            wr_data <= reg_val[i];
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    function automatic sample_t make_sample(input logic kind, input logic [1:0] axis,
                                            input int stick, input int err,
                                            input logic airborne, input int pp, input int pi);
        sample_t s;
        s.kind = kind;
        s.axis = axis;
        s.stick = 12'(stick);
        s.error = 16'(err);
        s.airborne = airborne;
        s.preset_p = 8'(pp);
        s.preset_i = 7'(pi);
        return s;
    endfunction

    function automatic void pick_wave(input int ax);
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
            wave_amp[ax] = $urandom_range(0, 60);
        else if (sel < 8)
            wave_amp[ax] = $urandom_range(100, 3000);
        else
            wave_amp[ax] = $urandom_range(3000, 32767);
        wave_half[ax] = $urandom_range(1, 20);
        wave_ph[ax] = 0;
    endfunction

    // Mostly oscillating in-band error per axis; the rest fully random
    task automatic run_traffic(input int count, input int well_pct);
        sample_t item;
        int      ax;
        int      db;
        int      h;
        int      mag_v;
        int      pick;
        for (int n = 0; n < count; n++)
        begin
            db = int'(tune_cfg.stick_deadband);
            if ($urandom_range(99) < well_pct)
            begin
                ax = ($urandom_range(49) == 0) ? 3 : $urandom_range(2);
                if (wave_half[ax] == 0 || $urandom_range(119) == 0)
                    pick_wave(ax);
                pick = $urandom_range(99);
                item = make_sample(KIND_SAMPLE, 2'(ax), 0, 0,
                                   ($urandom_range(9) < 7), 0, 0);
                if (pick < 4)
                begin
                    item.kind = KIND_PRESET;
                    item.preset_p = 8'($urandom_range(200));
                    item.preset_i = 7'($urandom_range(100));
                end
                else if (pick < 8)
                begin
                    mag_v = $urandom_range(db + 1, 2048);
                    item.stick = (mag_v == 2048 || $urandom_range(1) == 0) ?
                                 12'(-mag_v) : 12'(mag_v);
                end
                else
                begin
                    item.stick = 12'(int'($urandom_range(2 * db)) - db);
                    h = wave_ph[ax] % (2 * wave_half[ax]);
                    mag_v = wave_amp[ax] * ((h % wave_half[ax]) + 1) / wave_half[ax];
                    mag_v += $urandom_range(wave_amp[ax] / 8);
                    if (mag_v > 32767)
                        mag_v = 32767;
                    item.error = (h < wave_half[ax]) ? 16'(mag_v) : 16'(-mag_v);
                    wave_ph[ax]++;
                end
            end
            else
            begin
                item.kind = 1'($urandom);
                item.axis = 2'($urandom);
                item.stick = 12'($urandom);
                item.error = 16'($urandom);
                item.airborne = 1'($urandom);
                item.preset_p = 8'($urandom);
                item.preset_i = 7'($urandom);
            end
            offer_sample(item);
        end
    endtask

    task automatic test_directed();
        int trunc_err [6] = '{-5, -4, -3, 3, 4, 5};
        // Presets above the limits, at zero and at the limits
        offer_sample(make_sample(KIND_PRESET, 0, 0, 0, 1, 255, 127));
        offer_sample(make_sample(KIND_PRESET, 1, 0, 0, 0, 0, 0));
        offer_sample(make_sample(KIND_PRESET, 2, 0, 0, 1, 200, 100));
        // Out-of-range axis, both kinds
        offer_sample(make_sample(KIND_PRESET, 3, 2047, -32768, 1, 255, 127));
        offer_sample(make_sample(KIND_SAMPLE, 3, 0, 32767, 1, 0, 0));
        // Error extremes with the stick on the deadband edges
        offer_sample(make_sample(KIND_SAMPLE, 0, 12, 32767, 1, 0, 0));
        offer_sample(make_sample(KIND_SAMPLE, 1, -12, -32768, 1, 0, 0));
        offer_sample(make_sample(KIND_SAMPLE, 2, 0, 0, 0, 0, 0));
        offer_sample(make_sample(KIND_SAMPLE, 2, 0, -32768, 1, 0, 0));
        // Stick extremes and just outside the deadband
        offer_sample(make_sample(KIND_SAMPLE, 0, -13, 500, 1, 0, 0));
        offer_sample(make_sample(KIND_SAMPLE, 1, 2047, 500, 1, 0, 0));
        offer_sample(make_sample(KIND_SAMPLE, 2, -2048, -500, 0, 0, 0));
        // Quarter error truncating toward zero around the sign change
        foreach (trunc_err[k])
            offer_sample(make_sample(KIND_SAMPLE, 0, 0, trunc_err[k], 1, 0, 0));
        offer_sample(make_sample(KIND_SAMPLE, 1, 5, 40, 0, 0, 0));
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        c = '0;
        apply_config(c);
        run_traffic(100, 90);
        c = '1;
        apply_config(c);
        run_traffic(100, 90);
        c = '{stick_deadband: 8'd255, rise_threshold: 8'd1, fall_threshold: 8'd1,
              wobble_hold: 8'd0, avg_error_band: 8'd1, i_window: 8'd0,
              wobble_amplitude: 8'd1, wobble_period: 8'd1};
        apply_config(c);
        run_traffic(100, 95);
    endtask

    task automatic test_wobble();
        cfg_t c;
        c = '{stick_deadband: 8'd40, rise_threshold: 8'd10, fall_threshold: 8'd15,
              wobble_hold: 8'd0, avg_error_band: 8'd15, i_window: 8'd4,
              wobble_amplitude: 8'd20, wobble_period: 8'd4};
        apply_config(c);
        run_traffic(150, 97);
        c.wobble_hold = 8'd2;
        c.wobble_amplitude = 8'd60;
        c.wobble_period = 8'd10;
        apply_config(c);
        run_traffic(150, 97);
    endtask

    // Hold the receiver off while samples keep coming, so the input stalls
    task automatic test_backpressure();
        hold_off_req = 300;
        steady_sender = 1'b1;
        run_traffic(60, 90);
        steady_sender = 1'b0;
    endtask

    task automatic test_random();
        cfg_t c;
        for (int phase = 0; phase < 8; phase++)
        begin
            c.stick_deadband = ($urandom_range(3) == 0) ?
                               8'($urandom_range(255)) : 8'($urandom_range(5, 60));
            c.rise_threshold = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
            c.fall_threshold = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
            c.wobble_hold = ($urandom_range(3) == 0) ?
                            8'($urandom_range(255)) : 8'($urandom_range(3));
            c.avg_error_band = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
            c.i_window = ($urandom_range(3) == 0) ?
                         8'($urandom_range(255)) : 8'($urandom_range(8));
            c.wobble_amplitude = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            c.wobble_period = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 30));
            apply_config(c);
            run_traffic(135, 85);
        end
    endtask

    initial
    begin
        sample_valid <= 1'b0;
        sample_in <= '0;
        wr_en <= 1'b0;
        wr_index <= '0;
        wr_data <= '0;
        rst_n <= 1'b0;
        tune_cfg = '{stick_deadband: 8'd12, rise_threshold: 8'd10, fall_threshold: 8'd15,
                     wobble_hold: 8'd10, avg_error_band: 8'd15, i_window: 8'd100,
                     wobble_amplitude: 8'd0, wobble_period: 8'd0};
        foreach (axis_q[a])
            axis_q[a] = '0;
        led_q = 1'b0;
        foreach (wave_half[a])
            wave_half[a] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_wobble();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
